// ----- hdl/rcw_pkg.sv -----
// rcw_pkg: types and constants shared by the RIFF chunk walker.
// Holds the phase and event codes, the result item layout and the
// result queue sizing. No dependencies.
package rcw_pkg;

   localparam logic [31:0] RIFF_ID   = 32'h4646_4952;
   localparam logic [31:0] FILE_HDR  = 32'd12;
   localparam logic [31:0] CHUNK_HDR = 32'd8;

   // configuration register indexes
   localparam logic CSR_BUFFER_LENGTH = 1'b0;
   localparam logic CSR_EXPECTED_FORM = 1'b1;

   // result queue: room for the two items one byte can cause, plus slack
   localparam int RES_DEPTH = 4;
   localparam int RES_PTR_W = $clog2(RES_DEPTH);
   localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_FILE = 3'd1,
      PH_CHDR = 3'd2,
      PH_SKIP = 3'd3,
      PH_STOP = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      EV_HDR_OK    = 3'd0,
      EV_CHUNK     = 3'd1,
      EV_BAD_HDR   = 3'd2,
      EV_CHUNK_ERR = 3'd3,
      EV_END       = 3'd4
   } event_type;

   typedef struct packed {
      event_type   ev;
      logic [31:0] code;
      logic [31:0] len;
      logic [31:0] off;
      logic        last;
   } res_entry_type;

endpackage

// ----- hdl/riff_chunk_walker_top.sv -----
// A result item is written into the 4-entry result queue when its byte is accepted
// and is shown on rsp_* once it reaches the queue head. Throughput: one byte per
// cycle; a byte that ends a header can cause two result items, which leave the
// queue one at a time. req_tready drops while fewer than two entries are free.
// Reset: synchronous, active high; clears the walk state, both config registers
// and the result queue. The block is idle until a byte flagged as first arrives.
module riff_chunk_walker_top
   import rcw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // byte stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] first_byte
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // [31:0] chunk_code, [63:32] chunk_length,
                                    // [95:64] payload_offset
   output logic [2:0]  rsp_tuser,   // [2:0] event_res
   output logic        rsp_tlast,   // last_of_run
   // configuration
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [31:0] csr_wdata
);

   logic [31:0] buf_len_ff, form_ff;

   phase_type   phase_ff, phase_in;
   logic [31:0] pos_ff, pos_in;
   logic [3:0]  fs_ff, fs_in;
   logic [31:0] bl_ff, bl_in;
   logic [31:0] hc_ff, hc_in;
   logic        pp_ff, pp_in;

   res_entry_type          res_q_ff [RES_DEPTH];
   logic [RES_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff, wr_nxt;
   logic [RES_CNT_W-1:0]   cnt_ff;

   logic        acc, pop, first, short_buf;
   phase_type   eff_phase;
   logic [31:0] eff_pos, eff_bl, eff_hc;
   logic [3:0]  eff_fs;
   logic        eff_pp;
   logic [4:0]  lane_base;
   logic [31:0] hc_ins, bl_ins, pos_inc;
   logic        len_lane;

   // file header checks
   logic        hdr_bad, hdr_end, hdr_err;
   // chunk header checks
   logic [2:0]  ci;
   logic        odd;
   logic [32:0] sum, diff;
   logic        overrun, ch_end, ch_err;
   logic [31:0] cur;
   // payload skip
   logic [31:0] bl_after;
   logic        pp_after, skip_done;

   res_entry_type r0, r1;
   logic [1:0]    push_n;

   assign acc   = req_tvalid & req_tready;
   assign pop   = rsp_tvalid & rsp_tready;
   assign first = req_tuser;
   assign short_buf = buf_len_ff < FILE_HDR;

   // a restart byte is handled as byte zero of a fresh file header
   assign eff_phase = first ? PH_FILE : phase_ff;
   assign eff_pos   = first ? 32'd0 : pos_ff;
   assign eff_fs    = first ? 4'd0  : fs_ff;
   assign eff_bl    = first ? 32'd0 : bl_ff;
   assign eff_hc    = first ? 32'd0 : hc_ff;
   assign eff_pp    = first ? 1'b0  : pp_ff;

   assign lane_base = {eff_fs[1:0], 3'b000};
   assign pos_inc   = eff_pos + 32'd1;
   assign len_lane  = (eff_fs[3:2] == 2'b01);

   always_comb begin
      hc_ins = eff_hc;
      bl_ins = eff_bl;
      hc_ins[lane_base +: 8] = req_tdata;
      bl_ins[lane_base +: 8] = req_tdata;
   end

   assign hdr_bad = eff_pp || (hc_ins != form_ff) ||
                    (({1'b0, eff_bl} + 33'd8) > {1'b0, buf_len_ff});
   assign hdr_end = buf_len_ff <= FILE_HDR;
   assign hdr_err = !hdr_end && (buf_len_ff < (FILE_HDR + CHUNK_HDR));

   // chunk size is complete once its top byte lands in bl_ins
   assign ci      = eff_fs[2:0];
   assign odd     = bl_ins[0];
   assign sum     = {1'b0, pos_inc} + {1'b0, bl_ins};
   assign diff    = {1'b0, buf_len_ff} - sum;
   assign overrun = (bl_ins > buf_len_ff) || diff[32];
   // cursor after payload and pad reaches the end, or leaves less than a header
   assign ch_end  = (diff == 33'd0) || (odd && diff == 33'd1);
   assign ch_err  = !ch_end && (odd ? (diff < 33'd9) : (diff < 33'd8));
   assign cur     = sum[31:0] + {31'd0, odd};

   assign bl_after  = (bl_ff != 32'd0) ? bl_ff - 32'd1 : 32'd0;
   assign pp_after  = (bl_ff != 32'd0) ? pp_ff : 1'b0;
   assign skip_done = (bl_after == 32'd0) && !pp_after;

   // next state
   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      fs_in    = fs_ff;
      bl_in    = bl_ff;
      hc_in    = hc_ff;
      pp_in    = pp_ff;
      if (acc) begin
         if (first && short_buf) begin
            phase_in = PH_STOP;
            pos_in   = 32'd0;
            fs_in    = 4'd0;
            bl_in    = 32'd0;
            hc_in    = 32'd0;
            pp_in    = 1'b0;
         end else begin
            unique case (eff_phase)
               PH_FILE: begin
                  phase_in = PH_FILE;
                  pos_in   = pos_inc;
                  fs_in    = eff_fs + 4'd1;
                  hc_in    = len_lane ? eff_hc : hc_ins;
                  bl_in    = len_lane ? bl_ins : eff_bl;
                  pp_in    = eff_pp;
                  if (eff_fs == 4'd3) begin
                     pp_in = (hc_ins != RIFF_ID);
                  end
                  if (eff_fs == 4'd11) begin
                     fs_in    = 4'd0;
                     bl_in    = 32'd0;
                     pp_in    = 1'b0;
                     hc_in    = 32'd0;
                     phase_in = (hdr_bad || hdr_end || hdr_err) ? PH_STOP : PH_CHDR;
                  end
               end
               PH_CHDR: begin
                  pos_in = pos_inc;
                  fs_in  = {1'b0, ci} + 4'd1;
                  if (ci[2]) begin
                     bl_in = bl_ins;
                  end else begin
                     hc_in = hc_ins;
                  end
                  if (ci == 3'd7) begin
                     fs_in = 4'd0;
                     if (overrun) begin
                        phase_in = PH_STOP;
                        bl_in    = 32'd0;
                     end else if (ch_end || ch_err) begin
                        phase_in = PH_STOP;
                        bl_in    = 32'd0;
                        pp_in    = 1'b0;
                     end else begin
                        bl_in    = bl_ins;
                        pp_in    = odd;
                        phase_in = ((bl_ins != 32'd0) || odd) ? PH_SKIP : PH_CHDR;
                     end
                  end
               end
               PH_SKIP: begin
                  pos_in = pos_inc;
                  bl_in  = bl_after;
                  pp_in  = pp_after;
                  if (skip_done) begin
                     phase_in = PH_CHDR;
                     fs_in    = 4'd0;
                  end
               end
               PH_IDLE, PH_STOP: begin
               end
               default: phase_in = PH_IDLE;
            endcase
         end
      end
   end

   // result items caused by the accepted byte
   always_comb begin
      r0     = '{ev: EV_BAD_HDR, code: 32'd0, len: 32'd0, off: 32'd0, last: 1'b1};
      r1     = '{ev: EV_END, code: 32'd0, len: 32'd0, off: buf_len_ff, last: 1'b1};
      push_n = 2'd0;
      if (acc) begin
         if (first && short_buf) begin
            push_n = 2'd1;
         end else if (eff_phase == PH_FILE && eff_fs == 4'd11) begin
            if (hdr_bad) begin
               push_n = 2'd1;
            end else begin
               r0.ev   = EV_HDR_OK;
               r0.code = hc_ins;
               r0.len  = eff_bl;
               r0.off  = FILE_HDR;
               if (hdr_end) begin
                  push_n = 2'd2;
               end else if (hdr_err) begin
                  r1.ev  = EV_CHUNK_ERR;
                  r1.off = FILE_HDR;
                  push_n = 2'd2;
               end else begin
                  push_n = 2'd1;
               end
            end
         end else if (eff_phase == PH_CHDR && ci == 3'd7) begin
            // the id is complete in the held code; this byte is the size's top byte
            r0.code = eff_hc;
            r0.len  = bl_ins;
            r0.off  = pos_inc;
            if (overrun) begin
               r0.ev  = EV_CHUNK_ERR;
               push_n = 2'd1;
            end else begin
               r0.ev = EV_CHUNK;
               if (ch_end) begin
                  push_n = 2'd2;
               end else if (ch_err) begin
                  r1.ev  = EV_CHUNK_ERR;
                  r1.off = cur;
                  push_n = 2'd2;
               end else begin
                  push_n = 2'd1;
               end
            end
         end
      end
      r0.last = (push_n == 2'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_len_ff <= 32'd0;
         form_ff    <= 32'd0;
         phase_ff   <= PH_IDLE;
         pos_ff     <= 32'd0;
         fs_ff      <= 4'd0;
         bl_ff      <= 32'd0;
         hc_ff      <= 32'd0;
         pp_ff      <= 1'b0;
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         cnt_ff     <= '0;
      end else begin
         if (csr_we && csr_addr == CSR_BUFFER_LENGTH) begin
            buf_len_ff <= csr_wdata;
         end
         if (csr_we && csr_addr == CSR_EXPECTED_FORM) begin
            form_ff <= csr_wdata;
         end
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         fs_ff     <= fs_in;
         bl_ff     <= bl_in;
         hc_ff     <= hc_in;
         pp_ff     <= pp_in;
         wr_ptr_ff <= wr_ptr_ff + RES_PTR_W'(push_n);
         rd_ptr_ff <= rd_ptr_ff + RES_PTR_W'(pop);
         cnt_ff    <= cnt_ff + RES_CNT_W'(push_n) - RES_CNT_W'(pop);
      end
   end

   assign wr_nxt = wr_ptr_ff + RES_PTR_W'(1);

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         res_q_ff[wr_ptr_ff] <= r0;
      end
      if (push_n == 2'd2) begin
         res_q_ff[wr_nxt] <= r1;
      end
   end

   assign req_tready = cnt_ff <= RES_CNT_W'(RES_DEPTH - 2);
   assign rsp_tvalid = cnt_ff != '0;
   assign rsp_tdata  = {res_q_ff[rd_ptr_ff].off, res_q_ff[rd_ptr_ff].len,
                        res_q_ff[rd_ptr_ff].code};
   assign rsp_tuser  = res_q_ff[rd_ptr_ff].ev;
   assign rsp_tlast  = res_q_ff[rd_ptr_ff].last;

`ifndef SYNTH
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= RES_CNT_W'(RES_DEPTH))
      else $error("result queue count out of range");

   a_restart_runs: assert property (@(posedge clock) disable iff (reset)
      acc && req_tuser |=> phase_ff != PH_IDLE)
      else $error("restart left the walker idle");

   a_short_buf: assert property (@(posedge clock) disable iff (reset)
      acc && req_tuser && short_buf |-> push_n == 2'd1 && r0.ev == EV_BAD_HDR)
      else $error("short buffer restart did not give one bad header item");

   a_short_stop: assert property (@(posedge clock) disable iff (reset)
      acc && req_tuser && short_buf |=> phase_ff == PH_STOP)
      else $error("short buffer restart did not stop the walk");
`endif

endmodule
